FILE: src/mcpwm_pkg.sv
// mcpwm_pkg: shared types and constants for the multi-channel pwm generator
// no dependencies; used by mcpwm_channel and multi_channel_pwm_generator_top
`default_nettype none

package mcpwm_pkg;

    localparam int LEN_W = 24;
    localparam int PCT_FULL = 100;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_DUTY  = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;
    localparam logic [1:0] OP_CONST = 2'd3;

    // drive modes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_ON  = 2'd1;
    localparam logic [1:0] MODE_PWM = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] channel;
        logic [7:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0] pin_levels;
        logic [3:0] pulsing_mask;
    } res_item_t;

    // decoded command broadcast to every channel
    typedef struct packed {
        logic             tick;
        logic             set_pwm;
        logic             set_const;
        logic             const_on;
        logic [LEN_W-1:0] high_len;
        logic [LEN_W-1:0] low_len;
    } chan_cmd_t;

    typedef struct packed {
        logic level;
        logic pulsing;
    } chan_status_t;

endpackage

`default_nettype wire

FILE: src/mcpwm_channel.sv
// mcpwm_channel: state and phase counter of one pwm channel
// depends on mcpwm_pkg
`default_nettype none

module mcpwm_channel (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 apply,
    input  wire logic                 sel,
    input  wire mcpwm_pkg::chan_cmd_t cmd,
    output mcpwm_pkg::chan_status_t   status_next
);

    logic [1:0]                  mode_reg, mode_next;
    logic                        pulse_reg, pulse_next;
    logic [mcpwm_pkg::LEN_W-1:0] ticks_reg, ticks_next;
    logic [mcpwm_pkg::LEN_W-1:0] high_reg, high_next;
    logic [mcpwm_pkg::LEN_W-1:0] low_reg, low_next;
    logic [mcpwm_pkg::LEN_W-1:0] reload_len;

    // zero length loads as one tick
    function automatic logic [mcpwm_pkg::LEN_W-1:0] load_len(
        input logic [mcpwm_pkg::LEN_W-1:0] len
    );
        return (len == '0) ? mcpwm_pkg::LEN_W'(1) : len;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        pulse_next = pulse_reg;
        ticks_next = ticks_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        reload_len = pulse_reg ? low_reg : high_reg;
        if (apply)
        begin
            if (cmd.tick)
            begin
                if (mode_reg == mcpwm_pkg::MODE_PWM)
                begin
                    if (ticks_reg <= mcpwm_pkg::LEN_W'(1))
                    begin
                        pulse_next = !pulse_reg;
                        ticks_next = load_len(reload_len);
                    end
                    else
                    begin
                        ticks_next = ticks_reg - mcpwm_pkg::LEN_W'(1);
                    end
                end
            end
            else if (sel && cmd.set_const)
            begin
                mode_next  = cmd.const_on ? mcpwm_pkg::MODE_ON : mcpwm_pkg::MODE_OFF;
                pulse_next = 1'b0;
                ticks_next = '0;
                high_next  = '0;
                low_next   = '0;
            end
            else if (sel && cmd.set_pwm)
            begin
                high_next = cmd.high_len;
                low_next  = cmd.low_len;
                // entering pwm starts a pulse right away
                if (mode_reg != mcpwm_pkg::MODE_PWM)
                begin
                    mode_next  = mcpwm_pkg::MODE_PWM;
                    pulse_next = 1'b1;
                    ticks_next = load_len(cmd.high_len);
                end
            end
        end
    end

    always_comb
    begin
        status_next.pulsing = (mode_next == mcpwm_pkg::MODE_PWM);
        status_next.level   = (mode_next == mcpwm_pkg::MODE_ON) ||
                              ((mode_next == mcpwm_pkg::MODE_PWM) && pulse_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= mcpwm_pkg::MODE_OFF;
            pulse_reg <= 1'b0;
            ticks_reg <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pulse_reg <= pulse_next;
            ticks_reg <= ticks_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/multi_channel_pwm_generator_top.sv
// multi_channel_pwm_generator_top: command decode, length scaling, result register
// depends on mcpwm_pkg and mcpwm_channel
// a transaction's result is registered, in the skid entry while an earlier result waits
// throughput: one transaction per cycle; all channel counters update in the accept cycle
// a skid entry takes one more transaction while a result waits, then input stalls
// reset: asynchronous, active low; every channel comes up constant off with the pin low
`default_nettype none

module multi_channel_pwm_generator_top #(
    parameter int CHANNEL_COUNT    = 4,
    parameter int STEPS_PER_PERIOD = 100,
    parameter int TICKS_PER_STEP   = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire mcpwm_pkg::cmd_item_t cmd_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output mcpwm_pkg::res_item_t      res_data
);

    localparam int LUT_DEPTH = 128;

    typedef logic [LUT_DEPTH-1:0][7:0] duty_lut_t;

    // pulse steps for each duty percent, worked out at elaboration
    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        lut = '0;
        for (int p = 0; p < mcpwm_pkg::PCT_FULL; p++)
        begin
            lut[p] = 8'((STEPS_PER_PERIOD * p) / mcpwm_pkg::PCT_FULL);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

    logic                        accept;
    logic                        pop;
    logic [7:0]                  pulse_steps;
    logic [7:0]                  space_steps;
    mcpwm_pkg::chan_cmd_t        cmd;
    mcpwm_pkg::chan_status_t     status [CHANNEL_COUNT];
    mcpwm_pkg::res_item_t        res_new;
    mcpwm_pkg::res_item_t        res_data_reg, skid_data_reg;
    logic                        res_valid_reg, skid_valid_reg;

    assign accept = cmd_valid && cmd_ready;
    assign pop    = res_valid_reg && res_ready;

    // opcode decode
    always_comb
    begin
        cmd.tick      = 1'b0;
        cmd.set_pwm   = 1'b0;
        cmd.set_const = 1'b0;
        cmd.const_on  = 1'b0;
        pulse_steps   = cmd_data.value;
        unique case (cmd_data.opcode)
            mcpwm_pkg::OP_TICK:
            begin
                cmd.tick = 1'b1;
            end
            mcpwm_pkg::OP_DUTY:
            begin
                pulse_steps = DUTY_LUT[cmd_data.value[6:0]];
                if (cmd_data.value == 8'd0)
                begin
                    cmd.set_const = 1'b1;
                end
                else if (cmd_data.value >= 8'(mcpwm_pkg::PCT_FULL))
                begin
                    cmd.set_const = 1'b1;
                    cmd.const_on  = 1'b1;
                end
                else
                begin
                    cmd.set_pwm = 1'b1;
                end
            end
            mcpwm_pkg::OP_RAW:
            begin
                if (cmd_data.value == 8'd0)
                begin
                    cmd.set_const = 1'b1;
                end
                else if (cmd_data.value >= 8'(STEPS_PER_PERIOD))
                begin
                    cmd.set_const = 1'b1;
                    cmd.const_on  = 1'b1;
                end
                else
                begin
                    cmd.set_pwm = 1'b1;
                end
            end
            mcpwm_pkg::OP_CONST:
            begin
                cmd.set_const = 1'b1;
                cmd.const_on  = (cmd_data.value != 8'd0);
            end
            default:
            begin
                cmd.tick = 1'b0;
            end
        endcase
        space_steps  = 8'(STEPS_PER_PERIOD) - pulse_steps;
        cmd.high_len = mcpwm_pkg::LEN_W'(mcpwm_pkg::LEN_W'(pulse_steps) *
                                         mcpwm_pkg::LEN_W'(TICKS_PER_STEP));
        cmd.low_len  = mcpwm_pkg::LEN_W'(mcpwm_pkg::LEN_W'(space_steps) *
                                         mcpwm_pkg::LEN_W'(TICKS_PER_STEP));
    end

    for (genvar g = 0; g < CHANNEL_COUNT; g++)
    begin : g_chan
        mcpwm_channel u_chan (
            .clk         (clk),
            .rst_n       (rst_n),
            .apply       (accept),
            .sel         (int'(cmd_data.channel) == g),
            .cmd         (cmd),
            .status_next (status[g])
        );
    end

    // only the first four channels are reported
    for (genvar b = 0; b < 4; b++)
    begin : g_res
        if (b < CHANNEL_COUNT)
        begin : g_used
            assign res_new.pin_levels[b]   = status[b].level;
            assign res_new.pulsing_mask[b] = status[b].pulsing;
        end
        else
        begin : g_unused
            assign res_new.pin_levels[b]   = 1'b0;
            assign res_new.pulsing_mask[b] = 1'b0;
        end
    end

    assign cmd_ready = !skid_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (res_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                res_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload, skid entry drains into the output register first
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                res_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (res_valid_reg && !pop)
            begin
                skid_data_reg <= res_new;
            end
            else
            begin
                res_data_reg <= res_new;
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/mcpwm_checker.sv
`timescale 1ns / 1ps
// mcpwm_checker: follows the channel state from accepted commands and checks each result
// depends on mcpwm_pkg; hands failure and outstanding counts to the testbench top

module mcpwm_checker #(
    parameter int CHANNEL_COUNT    = 4,
    parameter int STEPS_PER_PERIOD = 100,
    parameter int TICKS_PER_STEP   = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire logic                 cmd_ready,
    input  wire mcpwm_pkg::cmd_item_t cmd_data,
    input  wire logic                 res_valid,
    input  wire logic                 res_ready,
    input  wire mcpwm_pkg::res_item_t res_data,
    output int                        error_count,
    output int                        pending_count
);

    logic [1:0]                  chan_mode       [4];
    logic                        chan_in_pulse   [4];
    logic [mcpwm_pkg::LEN_W-1:0] chan_ticks_left [4];
    logic [mcpwm_pkg::LEN_W-1:0] chan_high_len   [4];
    logic [mcpwm_pkg::LEN_W-1:0] chan_low_len    [4];

    mcpwm_pkg::res_item_t expected_levels_q[$];
    int                   fail_total;

    function automatic logic [mcpwm_pkg::LEN_W-1:0] reload_len(
        input logic [mcpwm_pkg::LEN_W-1:0] len
    );
        return (len == '0) ? mcpwm_pkg::LEN_W'(1) : len;
    endfunction

    task automatic hold_constant(input int c, input logic on);
        chan_mode[c]       = on ? mcpwm_pkg::MODE_ON : mcpwm_pkg::MODE_OFF;
        chan_in_pulse[c]   = 1'b0;
        chan_ticks_left[c] = '0;
        chan_high_len[c]   = '0;
        chan_low_len[c]    = '0;
    endtask

    // new lengths only take effect at the next reload unless the channel starts modulating
    task automatic load_pwm(input int c, input int pulse_steps);
        int space_steps;
        space_steps      = STEPS_PER_PERIOD - pulse_steps;
        chan_high_len[c] = mcpwm_pkg::LEN_W'(pulse_steps * TICKS_PER_STEP);
        chan_low_len[c]  = mcpwm_pkg::LEN_W'(space_steps * TICKS_PER_STEP);
        if (chan_mode[c] != mcpwm_pkg::MODE_PWM)
        begin
            chan_mode[c]       = mcpwm_pkg::MODE_PWM;
            chan_in_pulse[c]   = 1'b1;
            chan_ticks_left[c] = reload_len(chan_high_len[c]);
        end
    endtask

    task automatic advance_tick();
        for (int c = 0; c < CHANNEL_COUNT && c < 4; c++)
        begin
            if (chan_mode[c] == mcpwm_pkg::MODE_PWM)
            begin
                if (chan_ticks_left[c] <= 1)
                begin
                    chan_in_pulse[c]   = ~chan_in_pulse[c];
                    chan_ticks_left[c] = reload_len(chan_in_pulse[c] ? chan_high_len[c]
                                                                     : chan_low_len[c]);
                end
                else
                begin
                    chan_ticks_left[c] = chan_ticks_left[c] - 1'b1;
                end
            end
        end
    endtask

    task automatic apply_command(input mcpwm_pkg::cmd_item_t cmd,
                                 output mcpwm_pkg::res_item_t res);
        int ch;
        int val;
        ch  = int'(cmd.channel);
        val = int'(cmd.value);
        if (cmd.opcode == mcpwm_pkg::OP_TICK)
        begin
            advance_tick();
        end
        else if (ch < CHANNEL_COUNT)
        begin
            case (cmd.opcode)
                mcpwm_pkg::OP_DUTY:
                begin
                    if (val == 0)
                        hold_constant(ch, 1'b0);
                    else if (val >= mcpwm_pkg::PCT_FULL)
                        hold_constant(ch, 1'b1);
                    else
                        load_pwm(ch, (STEPS_PER_PERIOD * val) / mcpwm_pkg::PCT_FULL);
                end
                mcpwm_pkg::OP_RAW:
                begin
                    if (val == 0)
                        hold_constant(ch, 1'b0);
                    else if (val >= STEPS_PER_PERIOD)
                        hold_constant(ch, 1'b1);
                    else
                        load_pwm(ch, val);
                end
                default:
                begin
                    hold_constant(ch, val != 0);
                end
            endcase
        end
        res = '0;
        for (int c = 0; c < CHANNEL_COUNT && c < 4; c++)
        begin
            if (chan_mode[c] == mcpwm_pkg::MODE_ON)
                res.pin_levels[c] = 1'b1;
            else if (chan_mode[c] == mcpwm_pkg::MODE_PWM)
                res.pin_levels[c] = chan_in_pulse[c];
            res.pulsing_mask[c] = (chan_mode[c] == mcpwm_pkg::MODE_PWM);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mcpwm_pkg::res_item_t expected;
        mcpwm_pkg::res_item_t predicted;
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
                hold_constant(c, 1'b0);
            expected_levels_q.delete();
            fail_total    = 0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            // results first: a result never belongs to a transaction accepted at the same edge
            if (res_valid && res_ready)
            begin
                if (expected_levels_q.size() == 0)
                begin
                    $error("result with no transaction waiting: pin_levels=%h pulsing_mask=%h",
                           res_data.pin_levels, res_data.pulsing_mask);
                    fail_total++;
                end
                else
                begin
                    expected = expected_levels_q.pop_front();
                    if (res_data.pin_levels !== expected.pin_levels)
                    begin
                        $error("pin_levels: expected %h, actual %h",
                               expected.pin_levels, res_data.pin_levels);
                        fail_total++;
                    end
                    if (res_data.pulsing_mask !== expected.pulsing_mask)
                    begin
                        $error("pulsing_mask: expected %h, actual %h",
                               expected.pulsing_mask, res_data.pulsing_mask);
                        fail_total++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                apply_command(cmd_data, predicted);
                expected_levels_q.push_back(predicted);
            end
            error_count   <= fail_total;
            pending_count <= expected_levels_q.size();
        end
    end

endmodule

FILE: verif/multi_channel_pwm_generator_top_tb.sv
`timescale 1ns / 1ps
// multi_channel_pwm_generator_top_tb: directed and random command traffic with idle phases
// depends on mcpwm_pkg, multi_channel_pwm_generator_top and mcpwm_checker

module multi_channel_pwm_generator_top_tb;

    localparam int CHANNELS   = 4;
    localparam int STEPS      = 100;
    localparam int TICKS      = 64;
    localparam int CLK_PERIOD = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cmd_valid = 1'b0;
    mcpwm_pkg::cmd_item_t cmd_data  = '0;
    logic                 res_ready = 1'b0;
    logic                 cmd_ready;
    logic                 res_valid;
    mcpwm_pkg::res_item_t res_data;
    int                   error_count;
    int                   pending_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    multi_channel_pwm_generator_top #(
        .CHANNEL_COUNT    (CHANNELS),
        .STEPS_PER_PERIOD (STEPS),
        .TICKS_PER_STEP   (TICKS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    mcpwm_checker #(
        .CHANNEL_COUNT    (CHANNELS),
        .STEPS_PER_PERIOD (STEPS),
        .TICKS_PER_STEP   (TICKS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd_data      (cmd_data),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= recv_stall_pct);

    // called at a rising edge; returns at the edge where the transaction is accepted
    task automatic send_cmd(input logic [1:0] op, input logic [1:0] ch, input logic [7:0] val);
        mcpwm_pkg::cmd_item_t item;
        item.opcode  = op;
        item.channel = ch;
        item.value   = val;
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        do @(posedge clk); while (!cmd_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // short widths expire quickly, long ones leave a short space
    function automatic logic [7:0] pick_width();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return 8'($urandom_range(1, 3));
        else if (r < 7)
            return 8'($urandom_range(96, 99));
        else if (r < 9)
            return 8'($urandom_range(1, 99));
        return 8'($urandom_range(255));
    endfunction

    task automatic run_random(input int count);
        int         target;
        int         burst;
        logic [1:0] ch;
        logic [1:0] op;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                ch = 2'($urandom_range(3));
                op = $urandom_range(1) ? mcpwm_pkg::OP_DUTY : mcpwm_pkg::OP_RAW;
                if ($urandom_range(2) == 0)
                    send_cmd(mcpwm_pkg::OP_CONST, ch,
                             $urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'd0);
                send_cmd(op, ch, pick_width());
                // a second set may land while modulating and then only changes the lengths
                if ($urandom_range(1))
                    send_cmd($urandom_range(1) ? mcpwm_pkg::OP_DUTY : mcpwm_pkg::OP_RAW, ch,
                             pick_width());
                if ($urandom_range(3) == 0)
                    send_cmd($urandom_range(1) ? mcpwm_pkg::OP_DUTY : mcpwm_pkg::OP_RAW,
                             2'($urandom_range(3)), pick_width());
                burst = $urandom_range(1, 150);
                if (burst > target - items_sent)
                    burst = target - items_sent;
                repeat (burst)
                begin
                    if ($urandom_range(99) < 2)
                        send_cmd(mcpwm_pkg::OP_CONST, 2'($urandom_range(3)),
                                 8'($urandom_range(1)));
                    else
                        send_cmd(mcpwm_pkg::OP_TICK, 2'($urandom_range(3)),
                                 8'($urandom_range(255)));
                end
            end
            else
            begin
                send_cmd(2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        #(CLK_PERIOD * 200_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: limits of duty and raw width, constant levels, mode changes
        send_cmd(mcpwm_pkg::OP_TICK,  2'd3, 8'hff);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd0, 8'd0);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd1, 8'd100);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd2, 8'd255);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd3, 8'd1);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd1, 8'd99);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd1, 8'd50);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd0, 8'd1);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd0, 8'd99);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd2, 8'd100);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd2, 8'd255);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd2, 8'd0);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd2, 8'd128);
        send_cmd(mcpwm_pkg::OP_CONST, 2'd3, 8'd0);
        send_cmd(mcpwm_pkg::OP_CONST, 2'd3, 8'd1);
        send_cmd(mcpwm_pkg::OP_CONST, 2'd3, 8'd255);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd3, 8'd2);
        send_cmd(mcpwm_pkg::OP_TICK,  2'd0, 8'd0);
        send_cmd(mcpwm_pkg::OP_DUTY,  2'd3, 8'd0);
        send_cmd(mcpwm_pkg::OP_RAW,   2'd1, 8'd0);
        send_cmd(mcpwm_pkg::OP_CONST, 2'd0, 8'd0);
        send_cmd(mcpwm_pkg::OP_TICK,  2'd1, 8'h5a);
        wait_drained();

        run_random(310);
        wait_drained();

        send_idle_pct  = 86;
        recv_stall_pct = 0;
        run_random(310);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 86;
        run_random(310);
        wait_drained();

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random(310);
        wait_drained();

        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
